// File: sv/ltm_pkg.sv
// ----------------------------------------------------------------------------
// ltm_pkg: shared types, constants and elaboration helpers
// Fixed-point constants of the log-domain tone curve, the configuration
// and sideband structs, and constant functions for the exp root table.
// ----------------------------------------------------------------------------
package ltm_pkg;

  // fraction bits of the internal log domain
  localparam int IFRAC = 30;
  localparam int LOG_FRAC_BITS_DEF = 16;
  // width of a log register and of ln of a Q16.16 value in Q.30
  localparam int LOGW = 24;
  localparam int LNW = 35;

  // ln(pi * 0.0001) in Q.30
  localparam logic signed [35:0] LN_PIX_Q30 = -36'sd8660383315;
  localparam logic [28:0] LN2_Q29 = 29'd372130559;
  localparam logic [29:0] LOG2E_Q29 = 30'd774541002;
  // exp argument limits, 12 and -13 in Q.30
  localparam logic signed [35:0] EXP_HI = 36'sd12884901888;
  localparam logic signed [35:0] EXP_LO = -36'sd13958643712;

  typedef enum logic [2:0] {
    CFG_EXPONENT     = 3'd0,
    CFG_INV_EXPONENT = 3'd1,
    CFG_LN_CURVE     = 3'd2,
    CFG_LN_INPUT     = 3'd3,
    CFG_LN_INV_MAX   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_FWD        = 3'd0,
    KIND_FWD_SCALED = 3'd1,
    KIND_REV        = 3'd2,
    KIND_REV_SCALED = 3'd3,
    KIND_LOG_SCALED = 3'd4
  } kind_t;

  typedef struct packed {
    logic [19:0]        ex;
    logic [19:0]        iex;
    logic signed [23:0] lt;
    logic signed [23:0] ls;
    logic signed [23:0] lm;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               zero;
    logic signed [23:0] ln_lum;
    logic [15:0]        pf;
  } side_t;

  // width of the pre-multiply log sum
  function automatic int sum_width(input int lfb);
    int lw;
    lw = LOGW + IFRAC - lfb;
    return ((lw > 36) ? lw : 36) + 2;
  endfunction

  // width of the final exp argument
  function automatic int z_width(input int lfb);
    return sum_width(lfb) + 12;
  endfunction

  // floor square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v = x;
    res = '0;
    bit_w = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q.30 by repeated floor square roots
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'd2 << IFRAC;
    for (int j = 1; j <= IFRAC; j++) begin
      if (j <= k) begin
        r = isqrt64(r << IFRAC);
      end
    end
    return r[31:0];
  endfunction

endpackage

// File: sv/ltm_log_unit.sv
// ----------------------------------------------------------------------------
// ltm_log_unit: pipelined natural log of a Q16.16 luminance
// Normalizes the input, extracts 30 log2 fraction bits by one squaring
// per stage, then scales by ln2 with rounding. Sideband rides along.
// ----------------------------------------------------------------------------
module ltm_log_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [31:0]                      in_lum,
  input  ltm_pkg::side_t                   in_side,
  output logic                             out_vld,
  output logic signed [ltm_pkg::LNW-1:0]   out_ln,
  output ltm_pkg::side_t                   out_side
);

  localparam int NSQ = ltm_pkg::IFRAC;

  logic                a_vld_r;
  logic [31:0]         a_lum_r;
  logic [4:0]          a_msb_r;
  ltm_pkg::side_t      a_side_r;
  logic [4:0]          msb_nxt;

  logic                vld_r  [0:NSQ];
  logic [31:0]         y_r    [0:NSQ];
  logic [NSQ-1:0]      frac_r [0:NSQ];
  logic signed [5:0]   e_r    [0:NSQ];
  ltm_pkg::side_t      sd_r   [0:NSQ];

  logic                m_vld_r;
  logic                m_neg_r;
  logic [63:0]         m_prod_r;
  ltm_pkg::side_t      m_side_r;
  logic signed [35:0]  m_arg;
  logic [34:0]         m_mag;

  logic                r_vld_r;
  logic signed [ltm_pkg::LNW-1:0] r_ln_r;
  ltm_pkg::side_t      r_side_r;
  logic [63:0]         r_sum;
  logic [34:0]         r_mag;

  // find the leading one
  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_lum[i]) begin
        msb_nxt = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_lum_r  <= in_lum;
    a_msb_r  <= msb_nxt;
    a_side_r <= in_side;
  end

  // normalize mantissa to [2^31, 2^32) and form the binary exponent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    y_r[0]    <= a_lum_r << (5'd31 - a_msb_r);
    frac_r[0] <= '0;
    e_r[0]    <= signed'({1'b0, a_msb_r}) - 6'sd16;
    sd_r[0]   <= a_side_r;
  end

  // one squaring step per stage, one log2 fraction bit each
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] ys;

    assign sq = 64'(y_r[k]) * 64'(y_r[k]);
    assign ys = sq[63:31];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      y_r[k+1]    <= ys[32] ? ys[32:1] : ys[31:0];
      frac_r[k+1] <= frac_r[k] | (ys[32] ? (NSQ'(1) << (NSQ - 1 - k)) : '0);
      e_r[k+1]    <= e_r[k];
      sd_r[k+1]   <= sd_r[k];
    end
  end

  // scale log2 by ln2: magnitude times constant
  assign m_arg = {e_r[NSQ], frac_r[NSQ]};
  assign m_mag = m_arg[35] ? 35'(-m_arg) : m_arg[34:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
    end else begin
      m_vld_r <= vld_r[NSQ];
      r_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_neg_r  <= m_arg[35];
    m_prod_r <= 64'(m_mag) * 64'(ltm_pkg::LN2_Q29);
    m_side_r <= sd_r[NSQ];
  end

  // round half away from zero and restore sign
  assign r_sum = m_prod_r + (64'd1 << 28);
  assign r_mag = r_sum[63:29];

  always_ff @(posedge clk) begin
    r_ln_r   <= m_neg_r ? -signed'(r_mag) : signed'(r_mag);
    r_side_r <= m_side_r;
  end

  assign out_vld  = r_vld_r;
  assign out_ln   = r_ln_r;
  assign out_side = r_side_r;

endmodule

// File: sv/ltm_curve.sv
// ----------------------------------------------------------------------------
// ltm_curve: log-domain tone curve
// Forms the exp argument from ln of the input and the curve registers:
// offset sum, exponent multiply with rounding, kind offsets, and the
// power-factor multiply for the log-input kind.
// ----------------------------------------------------------------------------
module ltm_curve #(
  parameter int LOG_FRAC_BITS = ltm_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  ltm_pkg::cfg_t                                  cfg,
  input  logic                                           in_vld,
  input  logic signed [ltm_pkg::LNW-1:0]                 in_ln,
  input  ltm_pkg::side_t                                 in_side,
  output logic                                           out_vld,
  output logic                                           out_kill,
  output logic signed [ltm_pkg::z_width(LOG_FRAC_BITS)-1:0] out_z
);

  localparam int LW  = ltm_pkg::LOGW + ltm_pkg::IFRAC - LOG_FRAC_BITS;
  localparam int SW  = ltm_pkg::sum_width(LOG_FRAC_BITS);
  localparam int PW  = SW + 20;
  localparam int ZW  = SW + 7;
  localparam int ZFW = ltm_pkg::z_width(LOG_FRAC_BITS);
  localparam int QW  = ZW + 16;

  // register log format to Q.30
  function automatic logic signed [LW-1:0] to_q30(input logic signed [23:0] v);
    logic signed [LW-1:0] w;
    w = LW'(v);
    return w <<< (ltm_pkg::IFRAC - LOG_FRAC_BITS);
  endfunction

  logic signed [SW-1:0] lq, lt_s, ls_s, lm_s, lnl_s, pix_s;
  logic signed [SW-1:0] a_nxt;
  logic [19:0]          m_nxt;
  logic                 kill_nxt;

  logic                 c0_vld_r, c0_kill_r;
  logic signed [SW-1:0] c0_a_r;
  logic [19:0]          c0_m_r;
  logic [2:0]           c0_kind_r;
  logic [15:0]          c0_pf_r;

  logic [SW-1:0]        c1_mag;
  logic                 c1_vld_r, c1_kill_r, c1_neg_r;
  logic [PW-1:0]        c1_prod_r;
  logic [2:0]           c1_kind_r;
  logic [15:0]          c1_pf_r;

  logic [PW-1:0]        c2_sum;
  logic [SW+3:0]        c2_mag;
  logic signed [ZW-1:0] c2_rs, c2_nxt;
  logic                 c2_vld_r, c2_kill_r, c2_log_r;
  logic signed [ZW-1:0] c2_z_r;
  logic [15:0]          c2_pf_r;

  logic [ZW-1:0]        c3_mag;
  logic                 c3_vld_r, c3_kill_r, c3_log_r, c3_neg_r;
  logic [QW-1:0]        c3_prod_r;
  logic signed [ZW-1:0] c3_z_r;

  logic [QW-1:0]        c4_sum;
  logic [ZW+3:0]        c4_mag;
  logic signed [ZFW-1:0] c4_q;
  logic                 c4_vld_r, c4_kill_r;
  logic signed [ZFW-1:0] c4_z_r;

  assign lq    = SW'(in_ln);
  assign lt_s  = SW'(to_q30(cfg.lt));
  assign ls_s  = SW'(to_q30(cfg.ls));
  assign lm_s  = SW'(to_q30(cfg.lm));
  assign lnl_s = SW'(to_q30(in_side.ln_lum));
  assign pix_s = SW'(ltm_pkg::LN_PIX_Q30);

  // select the multiply operand and factor
  always_comb begin
    case (in_side.kind)
      ltm_pkg::KIND_REV: begin
        a_nxt = lq - lt_s;
        m_nxt = cfg.iex;
      end
      ltm_pkg::KIND_REV_SCALED: begin
        a_nxt = lq - lm_s - lt_s;
        m_nxt = cfg.iex;
      end
      ltm_pkg::KIND_LOG_SCALED: begin
        a_nxt = ls_s + lnl_s + pix_s;
        m_nxt = cfg.ex;
      end
      default: begin
        a_nxt = ls_s + lq + pix_s;
        m_nxt = cfg.ex;
      end
    endcase
    kill_nxt = (in_side.kind > 3'(ltm_pkg::KIND_LOG_SCALED)) ||
               ((in_side.kind != 3'(ltm_pkg::KIND_LOG_SCALED)) && in_side.zero);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_vld_r <= 1'b0;
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
      c4_vld_r <= 1'b0;
    end else begin
      c0_vld_r <= in_vld;
      c1_vld_r <= c0_vld_r;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
      c4_vld_r <= c3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c0_a_r    <= a_nxt;
    c0_m_r    <= m_nxt;
    c0_kind_r <= in_side.kind;
    c0_pf_r   <= in_side.pf;
    c0_kill_r <= kill_nxt;
  end

  // exponent multiply on the magnitude
  assign c1_mag = c0_a_r[SW-1] ? SW'(-c0_a_r) : SW'(c0_a_r);

  always_ff @(posedge clk) begin
    c1_neg_r  <= c0_a_r[SW-1];
    c1_prod_r <= PW'(c1_mag) * PW'(c0_m_r);
    c1_kind_r <= c0_kind_r;
    c1_pf_r   <= c0_pf_r;
    c1_kill_r <= c0_kill_r;
  end

  // round, restore sign, add kind offsets
  assign c2_sum = c1_prod_r + PW'(32768);
  assign c2_mag = c2_sum[PW-1:16];
  assign c2_rs  = c1_neg_r ? -signed'(ZW'({1'b0, c2_mag})) : signed'(ZW'({1'b0, c2_mag}));

  always_comb begin
    case (c1_kind_r)
      ltm_pkg::KIND_FWD:        c2_nxt = c2_rs + ZW'(lt_s);
      ltm_pkg::KIND_FWD_SCALED: c2_nxt = c2_rs + ZW'(lt_s) + ZW'(lm_s);
      ltm_pkg::KIND_REV:        c2_nxt = c2_rs - ZW'(ls_s) - ZW'(pix_s);
      ltm_pkg::KIND_REV_SCALED: c2_nxt = c2_rs - ZW'(ls_s) - ZW'(pix_s);
      ltm_pkg::KIND_LOG_SCALED: c2_nxt = c2_rs + ZW'(lt_s) + ZW'(lm_s);
      default:                  c2_nxt = c2_rs;
    endcase
  end

  always_ff @(posedge clk) begin
    c2_z_r    <= c2_nxt;
    c2_log_r  <= (c1_kind_r == 3'(ltm_pkg::KIND_LOG_SCALED));
    c2_pf_r   <= c1_pf_r;
    c2_kill_r <= c1_kill_r;
  end

  // power-factor multiply
  assign c3_mag = c2_z_r[ZW-1] ? ZW'(-c2_z_r) : ZW'(c2_z_r);

  always_ff @(posedge clk) begin
    c3_neg_r  <= c2_z_r[ZW-1];
    c3_prod_r <= QW'(c3_mag) * QW'(c2_pf_r);
    c3_z_r    <= c2_z_r;
    c3_log_r  <= c2_log_r;
    c3_kill_r <= c2_kill_r;
  end

  // round the scaled argument, pass others through
  assign c4_sum = c3_prod_r + QW'(2048);
  assign c4_mag = c4_sum[QW-1:12];
  assign c4_q   = c3_neg_r ? -signed'({1'b0, c4_mag}) : signed'({1'b0, c4_mag});

  always_ff @(posedge clk) begin
    c4_z_r    <= c3_log_r ? c4_q : ZFW'(c3_z_r);
    c4_kill_r <= c3_kill_r;
  end

  assign out_vld  = c4_vld_r;
  assign out_kill = c4_kill_r;
  assign out_z    = c4_z_r;

endmodule

// File: sv/ltm_exp_unit.sv
// ----------------------------------------------------------------------------
// ltm_exp_unit: pipelined exp to Q16.16 with saturation
// Range checks, scale by log2(e), split into integer and fraction, one
// conditional root multiply per fraction bit, then final shift and clip.
// ----------------------------------------------------------------------------
module ltm_exp_unit #(
  parameter int LOG_FRAC_BITS = ltm_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_vld,
  input  logic                                             in_kill,
  input  logic signed [ltm_pkg::z_width(LOG_FRAC_BITS)-1:0] in_z,
  output logic                                             out_vld,
  output logic [31:0]                                      out_mapped,
  output logic                                             out_sat
);

  localparam int ZFW = ltm_pkg::z_width(LOG_FRAC_BITS);
  localparam int NB  = ltm_pkg::IFRAC;

  typedef struct packed {
    logic kill;
    logic hi;
    logic lo;
  } eflag_t;

  logic signed [35:0] zc;
  eflag_t             fl_nxt;

  logic               e0_vld_r, e0_neg_r;
  logic [34:0]        e0_mag_r;
  eflag_t             e0_fl_r;

  logic               e1_vld_r, e1_neg_r;
  logic [63:0]        e1_prod_r;
  eflag_t             e1_fl_r;

  logic [63:0]        e2_sum;
  logic [34:0]        e2_mag;
  logic signed [35:0] e2_t;

  logic               vld_r [0:NB];
  logic [31:0]        p_r   [0:NB];
  logic [NB-1:0]      f_r   [0:NB];
  logic signed [5:0]  n_r   [0:NB];
  eflag_t             fl_r  [0:NB];

  logic signed [6:0]  sh;
  logic [5:0]         rs;
  logic [39:0]        val;

  logic               o_vld_r, o_sat_r;
  logic [31:0]        o_map_r;

  // range checks and magnitude
  assign zc = in_z[35:0];
  assign fl_nxt.kill = in_kill;
  assign fl_nxt.hi = (in_z >= ZFW'(ltm_pkg::EXP_HI));
  assign fl_nxt.lo = (in_z < ZFW'(ltm_pkg::EXP_LO));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_vld_r <= 1'b0;
      e1_vld_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      e0_vld_r <= in_vld;
      e1_vld_r <= e0_vld_r;
      vld_r[0] <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e0_neg_r <= zc[35];
    e0_mag_r <= zc[35] ? 35'(-zc) : zc[34:0];
    e0_fl_r  <= fl_nxt;
  end

  // scale by log2(e)
  always_ff @(posedge clk) begin
    e1_neg_r  <= e0_neg_r;
    e1_prod_r <= 64'(e0_mag_r) * 64'(ltm_pkg::LOG2E_Q29);
    e1_fl_r   <= e0_fl_r;
  end

  // round and split into floor integer and fraction
  assign e2_sum = e1_prod_r + (64'd1 << 28);
  assign e2_mag = e2_sum[63:29];
  assign e2_t   = e1_neg_r ? -signed'({1'b0, e2_mag}) : signed'({1'b0, e2_mag});

  always_ff @(posedge clk) begin
    p_r[0]  <= 32'd1 << NB;
    f_r[0]  <= e2_t[NB-1:0];
    n_r[0]  <= e2_t[35:NB];
    fl_r[0] <= e1_fl_r;
  end

  // one root of two per fraction bit
  for (genvar j = 0; j < NB; j++) begin : g_root
    localparam logic [31:0] ROOT = ltm_pkg::exp_root(j + 1);
    logic [63:0] prod;
    logic [63:0] psum;

    assign prod = 64'(p_r[j]) * 64'(ROOT);
    assign psum = prod + (64'd1 << (NB - 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      p_r[j+1]  <= f_r[j][NB-1-j] ? psum[61:30] : p_r[j];
      f_r[j+1]  <= f_r[j];
      n_r[j+1]  <= n_r[j];
      fl_r[j+1] <= fl_r[j];
    end
  end

  // scale by 2^n into Q16.16 with half-up rounding
  always_comb begin
    sh  = 7'(n_r[NB]) - 7'sd14;
    rs  = 6'(-sh);
    if (!sh[6]) begin
      val = 40'(p_r[NB]) << sh[2:0];
    end else begin
      val = (40'(p_r[NB]) + (40'd1 << (rs - 6'd1))) >> rs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      o_sat_r <= 1'b0;
    end else begin
      o_vld_r <= vld_r[NB];
      o_sat_r <= vld_r[NB] && !fl_r[NB].kill && !fl_r[NB].lo &&
                 (fl_r[NB].hi || (val[39:32] != 8'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (fl_r[NB].kill || fl_r[NB].lo) begin
      o_map_r <= '0;
    end else if (fl_r[NB].hi || (val[39:32] != 8'd0)) begin
      o_map_r <= '1;
    end else begin
      o_map_r <= val[31:0];
    end
  end

  assign out_vld    = o_vld_r;
  assign out_mapped = o_map_r;
  assign out_sat    = o_sat_r;

endmodule

// File: sv/luminance_tone_mapper.sv
// ----------------------------------------------------------------------------
// luminance_tone_mapper: power-law tone curve in the log domain
// Top level: configuration registers, input sideband, and the log,
// curve and exp pipelines.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle (busy never rises) and
// delivers each result as a one-cycle strobe on out_valid; the receiver
// cannot hold results off, and none is needed. The pipeline is made of
// the 30-stage squaring chain of the log unit and the 30-stage root
// product chain of the exp unit, plus 13 stages of setup, multiply and
// rounding. Configuration writes take effect at once and should only be
// issued while no item is in flight.
module luminance_tone_mapper #(
  parameter int LOG_FRAC_BITS = ltm_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_luminance,
  input  logic signed [23:0] in_ln_luminance,
  input  logic [15:0]        in_power_factor,
  output logic               out_valid,
  output logic [31:0]        out_mapped,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam int ZFW = ltm_pkg::z_width(LOG_FRAC_BITS);

  ltm_pkg::cfg_t   cfg_r;
  ltm_pkg::side_t  in_side;
  logic            in_vld;

  logic            lg_vld;
  logic signed [ltm_pkg::LNW-1:0] lg_ln;
  ltm_pkg::side_t  lg_side;

  logic            cv_vld, cv_kill;
  logic signed [ZFW-1:0] cv_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ex  <= 20'd98644;
      cfg_r.iex <= 20'd43540;
      cfg_r.lt  <= 24'sd89798;
      cfg_r.ls  <= 24'sd0;
      cfg_r.lm  <= -24'sd301804;
    end else if (cfg_we) begin
      case (cfg_index)
        ltm_pkg::CFG_EXPONENT:     cfg_r.ex  <= cfg_wdata[19:0];
        ltm_pkg::CFG_INV_EXPONENT: cfg_r.iex <= cfg_wdata[19:0];
        ltm_pkg::CFG_LN_CURVE:     cfg_r.lt  <= signed'(cfg_wdata);
        ltm_pkg::CFG_LN_INPUT:     cfg_r.ls  <= signed'(cfg_wdata);
        ltm_pkg::CFG_LN_INV_MAX:   cfg_r.lm  <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // accept every cycle; bundle sideband
  assign busy           = 1'b0;
  assign in_vld         = start && !busy;
  assign in_side.kind   = in_kind;
  assign in_side.zero   = (in_luminance == 32'd0);
  assign in_side.ln_lum = in_ln_luminance;
  assign in_side.pf     = in_power_factor;

  ltm_log_unit u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_lum   (in_luminance),
    .in_side  (in_side),
    .out_vld  (lg_vld),
    .out_ln   (lg_ln),
    .out_side (lg_side)
  );

  ltm_curve #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_curve (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (lg_vld),
    .in_ln    (lg_ln),
    .in_side  (lg_side),
    .out_vld  (cv_vld),
    .out_kill (cv_kill),
    .out_z    (cv_z)
  );

  ltm_exp_unit #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_exp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (cv_vld),
    .in_kill    (cv_kill),
    .in_z       (cv_z),
    .out_vld    (out_valid),
    .out_mapped (out_mapped),
    .out_sat    (out_saturated)
  );

  // saturation only comes with a result transfer
  a_sat_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> out_valid)
    else $error("saturation flag without result strobe");

  // a clipped result is all ones
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> (out_mapped == 32'hFFFF_FFFF))
    else $error("saturated result not clipped to maximum");

  // exponent write lands in its register
  a_cfg_ex: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == 3'(ltm_pkg::CFG_EXPONENT))) |=>
      (cfg_r.ex == $past(cfg_wdata[19:0])))
    else $error("exponent register write lost");

endmodule
